// ----- rtl/ivm_pkg.sv -----
package ivm_pkg;

	typedef struct packed {
		logic               action;
		logic signed [31:0] range_begin;
		logic signed [31:0] range_end;
		logic [7:0]         new_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] found_value;
		logic [1:0] status;
	} out_item_t;

	localparam logic ACT_ASSIGN = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_LOAD  = 3'd1,
		CMD_SCAN  = 3'd2,
		CMD_BUILD = 3'd3,
		CMD_COPY  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic build_done;
		logic copy_done;
		logic empty_range;
		logic overflow;
	} dp_status_t;

endpackage

// ----- rtl/interval_value_map.sv -----
// interval_value_map: sorted breakpoint table mapping signed 32-bit keys to
// 8-bit values, everything else at default_value.
// input channel in_valid/in_ready carries in_item: action 0 assigns new_value
// over [range_begin, range_end), action 1 looks up range_begin.
// output channel out_valid/out_ready carries one out_item per input item:
// found_value (lookup only) and status (done, empty range, table full).
// default_value is written through cfg_we/cfg_data; the user must do this only
// while the block is idle, and the block itself does not enforce it.
// one item at a time: the live table is read in a search pass and a rebuild
// pass, the new table in a copy pass; a lookup or an empty range ends after
// the search pass. the result waits in an output register; the next item is
// taken once that register is free or being read, so a stalled receiver holds
// the block. reset empties the table at once (count zero), default_value
// reads zero.
module interval_value_map
	import ivm_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [7:0] cfg_data
);

	logic [7:0] default_value_q;
	cmd_t       cmd;
	dp_status_t stat;
	logic [7:0] found_value;
	in_item_t   item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) default_value_q <= '0;
		else if (cfg_we) default_value_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_item;
	end

	ivm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
		.out_item, .stat, .found_value, .cmd
	);

	ivm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .item(item_q), .default_value(default_value_q),
		.stat, .found_value
	);

endmodule

// ----- rtl/ivm_datapath.sv -----
module ivm_datapath
	import ivm_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  in_item_t   item,
	input  logic [7:0] default_value,
	output dp_status_t stat,
	output logic [7:0] found_value
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(TABLE_DEPTH + 3);

	// live table and scratch table, each a memory
	logic [31:0] keys_mem [TABLE_DEPTH];
	logic [7:0]  vals_mem [TABLE_DEPTH];
	logic [31:0] nkeys_mem [TABLE_DEPTH];
	logic [7:0]  nvals_mem [TABLE_DEPTH];

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic [31:0]   b_q, e_q;
	logic [7:0]    v_q;
	logic [7:0]    endv_q;
	logic [7:0]    prev_q;
	logic [7:0]    at_b_q;
	logic          empty_q;
	logic [1:0]    phase_q; // 0 before or inside range, 1 end breakpoint insert pending, 2 after range
	logic          ins_done_q;
	logic [31:0]   rk_q;
	logic [7:0]    rv_q;
	logic          rd_ok_q;

	function automatic logic kless(input logic [31:0] a, input logic [31:0] c);
		return $signed(a) < $signed(c);
	endfunction

	// registered memory read at idx
	always_ff @(posedge clk) begin
		rk_q <= keys_mem[idx_q[AW-1:0]];
		rv_q <= vals_mem[idx_q[AW-1:0]];
	end

	logic scan_end, build_end, copy_end;
	assign scan_end  = rd_ok_q && idx_q >= count_q;
	assign build_end = ins_done_q && (idx_q >= count_q) && rd_ok_q;
	assign copy_end  = rd_ok_q && NW'(idx_q) >= n_q;

	// pending insert of begin/end breakpoints at range start
	logic [1:0]  ins_cnt;
	logic [31:0] ins_k0, ins_k1;
	logic [7:0]  ins_v0, ins_v1;
	always_comb begin
		ins_cnt = 2'd0;
		ins_k0 = b_q; ins_v0 = v_q;
		ins_k1 = e_q; ins_v1 = endv_q;
		if (prev_q != v_q) begin
			ins_cnt = 2'd1;
			if (endv_q != v_q) ins_cnt = 2'd2;
		end else if (endv_q != v_q) begin
			ins_cnt = 2'd1;
			ins_k0 = e_q; ins_v0 = endv_q;
		end
	end

	logic [NW-1:0] ovf_lim;
	assign ovf_lim = NW'(TABLE_DEPTH);

	logic [NW-1:0] n_next;
	logic [31:0]   wk;
	logic [7:0]    wv;
	logic          we;
	logic          adv;
	logic          ins_now;
	logic          ins_second;

	always_comb begin
		n_next = n_q;
		wk = rk_q; wv = rv_q; we = 1'b0;
		adv = 1'b0; ins_now = 1'b0; ins_second = 1'b0;
		if (cmd == CMD_BUILD && rd_ok_q && !ins_done_q) begin
			if (idx_q < count_q && kless(rk_q, b_q)) begin
				we = 1'b1; adv = 1'b1;
			end else begin
				ins_now = 1'b1;
				if (ins_cnt != 2'd0) we = 1'b1;
				wk = ins_k0; wv = ins_v0;
				if (ins_cnt == 2'd2 && !phase_q[0]) ins_second = 1'b1;
				if (phase_q[0]) begin
					wk = ins_k1; wv = ins_v1;
				end
			end
		end else if (cmd == CMD_BUILD && rd_ok_q && ins_done_q && idx_q < count_q) begin
			adv = 1'b1;
			if (phase_q == 2'd2 || kless(e_q, rk_q)) we = 1'b1;
		end
		if (we) n_next = n_q + NW'(1);
	end

	always_ff @(posedge clk) begin
		if (we && n_q < ovf_lim) begin
			nkeys_mem[n_q[AW-1:0]] <= wk;
			nvals_mem[n_q[AW-1:0]] <= wv;
		end
	end

	logic [31:0] ck_q;
	logic [7:0]  cv_q;
	always_ff @(posedge clk) begin
		ck_q <= nkeys_mem[idx_q[AW-1:0]];
		cv_q <= nvals_mem[idx_q[AW-1:0]];
	end

	logic [CW-1:0] cidx_q;
	logic          cvalid_q;
	always_ff @(posedge clk) begin
		if (cvalid_q) begin
			keys_mem[cidx_q[AW-1:0]] <= ck_q;
			vals_mem[cidx_q[AW-1:0]] <= cv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			rd_ok_q    <= 1'b0;
			ins_done_q <= 1'b0;
			phase_q    <= 2'd0;
			empty_q    <= 1'b0;
			cvalid_q   <= 1'b0;
			cidx_q     <= '0;
			b_q <= '0; e_q <= '0; v_q <= '0;
			endv_q <= '0; prev_q <= '0; at_b_q <= '0;
		end else begin
			cvalid_q <= 1'b0;
			unique case (cmd)
				CMD_LOAD: begin
					b_q     <= item.range_begin;
					e_q     <= item.range_end;
					v_q     <= item.new_value;
					empty_q <= !kless(item.range_begin, item.range_end);
					idx_q   <= '0;
					rd_ok_q <= 1'b0;
					at_b_q  <= default_value;
					endv_q  <= default_value;
					prev_q  <= default_value;
					n_q     <= '0;
					ins_done_q <= 1'b0;
					phase_q <= 2'd0;
				end
				CMD_SCAN: begin
					// one pass finds value at begin (lookup) and value at end
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (idx_q < count_q) begin
						if (!kless(b_q, rk_q)) at_b_q <= rv_q;
						if (!kless(e_q, rk_q)) endv_q <= rv_q;
						idx_q   <= idx_q + CW'(1);
						rd_ok_q <= 1'b0;
					end
				end
				CMD_BUILD: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (build_end) begin
						// rewind for the copy pass
						idx_q   <= '0;
						rd_ok_q <= 1'b0;
					end else begin
						n_q <= n_next;
						if (adv) begin
							if (!ins_done_q) prev_q <= rv_q;
							idx_q   <= idx_q + CW'(1);
							rd_ok_q <= 1'b0;
							if (ins_done_q && kless(e_q, rk_q)) phase_q <= 2'd2;
						end
						if (ins_now) begin
							if (ins_second) phase_q <= 2'd1;
							else begin
								ins_done_q <= 1'b1;
								phase_q    <= 2'd0;
							end
						end
					end
				end
				CMD_COPY: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (NW'(idx_q) < n_q) begin
						cvalid_q <= 1'b1;
						cidx_q   <= idx_q;
						idx_q    <= idx_q + CW'(1);
						rd_ok_q  <= 1'b0;
					end else begin
						count_q <= n_q[CW-1:0];
					end
				end
				default: begin
					idx_q   <= '0;
					rd_ok_q <= 1'b0;
				end
			endcase
		end
	end

	assign stat.scan_done   = scan_end;
	assign stat.build_done  = build_end;
	assign stat.copy_done   = copy_end;
	assign stat.empty_range = empty_q;
	assign stat.overflow    = n_q > ovf_lim;
	assign found_value      = at_b_q;

endmodule

// ----- rtl/ivm_ctrl.sv -----
module ivm_ctrl
	import ivm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  dp_status_t stat,
	input  logic [7:0] found_value,
	output cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_RST   = 7'b0001000,
		S_BUILD = 7'b0010000,
		S_COPY  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t    state_q, state_d;
	logic      act_q;
	out_item_t res_q;
	logic      res_valid_q;
	logic      load_res;
	out_item_t res_d;

	assign in_ready  = (state_q == S_IDLE) && (!res_valid_q || out_ready);
	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		load_res = 1'b0;
		res_d    = '0;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) state_d = S_LOAD;
			S_LOAD: begin
				cmd = CMD_LOAD;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd = CMD_SCAN;
				if (stat.scan_done) begin
					if (act_q == ACT_LOOKUP) begin
						res_d.found_value = found_value;
						res_d.status = ST_DONE;
						state_d = S_OUT;
					end else if (stat.empty_range) begin
						res_d.status = ST_EMPTY;
						state_d = S_OUT;
					end else begin
						state_d = S_RST;
					end
				end
			end
			S_RST: state_d = S_BUILD;
			S_BUILD: begin
				cmd = CMD_BUILD;
				if (stat.build_done) begin
					if (stat.overflow) begin
						res_d.status = ST_FULL;
						state_d = S_OUT;
					end else begin
						state_d = S_COPY;
					end
				end
			end
			S_COPY: begin
				cmd = CMD_COPY;
				if (stat.copy_done) begin
					res_d.status = ST_DONE;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				load_res = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	out_item_t pend_q;
	always_ff @(posedge clk) begin
		if (state_d == S_OUT && state_q != S_OUT) pend_q <= res_d;
		if (state_q == S_IDLE && in_valid && in_ready) act_q <= in_item.action;
		if (load_res) res_q <= pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

endmodule
